// ----- design/vpa_pkg.sv -----
`default_nettype none
package vpa_pkg;

	localparam int ADDR_BITS  = 16;
	localparam int OWNER_BITS = 8;

	localparam logic [ADDR_BITS-1:0] RESET_BASE = 16'd40;
	localparam logic [ADDR_BITS-1:0] RESET_SIZE = 16'd600;

	// Configuration register indexes.
	localparam logic [1:0] CFG_POLICY = 2'd0;
	localparam logic [1:0] CFG_BASE   = 2'd1;
	localparam logic [1:0] CFG_SIZE   = 2'd2;

	// Fit policies; the unused code behaves as first fit.
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_NEXT  = 2'd1;
	localparam logic [1:0] POL_BEST  = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_NOOWNER = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_STEP,
		OP_ALLOC,
		OP_MERGE_LO,
		OP_MERGE_HI,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic scan_end;
		logic found;
		logic req_zero;
		logic exact;
		logic full;
	} dp_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_MERGE,
		S_FINISH,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

// ----- design/vpa_dp.sv -----
`default_nettype none
module vpa_dp #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire  logic                             clk,
	input  wire  logic                             arst_n,
	input  wire  logic                             cfg_we,
	input  wire  logic [1:0]                       cfg_index,
	input  wire  logic [vpa_pkg::ADDR_BITS-1:0]    cfg_data,
	input  wire  logic                             in_cmd,
	input  wire  logic [vpa_pkg::OWNER_BITS-1:0]   in_owner,
	input  wire  logic [vpa_pkg::ADDR_BITS-1:0]    in_size,
	input  wire  vpa_pkg::dp_cmd_t                 cmd,
	output vpa_pkg::dp_stat_t                      stat,
	output logic [1:0]                             res_status,
	output logic [vpa_pkg::ADDR_BITS-1:0]          res_start
);
	import vpa_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [ADDR_BITS-1:0]  start_q [MAX_ENTRIES];
	logic [ADDR_BITS-1:0]  size_q  [MAX_ENTRIES];
	logic                  used_q  [MAX_ENTRIES];
	logic [OWNER_BITS-1:0] owner_q [MAX_ENTRIES];

	logic [CW-1:0]         count_q, step_q;
	logic [IW-1:0]         rover_q, pick_q, idx_q;
	logic                  found_q, free_q;
	logic [ADDR_BITS-1:0]  best_q, req_q, rel_q, base_q, psize_q;
	logic [OWNER_BITS-1:0] own_q;
	logic [1:0]            policy_q;
	logic [1:0]            res_status_q;
	logic [ADDR_BITS-1:0]  res_start_q;

	logic          match, best_mode, idx_wrap, lo_merge, hi_merge, exact;
	logic [IW-1:0] p, lo_rover, hi_rover1, hi_rover;
	logic [CW-1:0] hi_count;

	assign p         = pick_q;
	assign best_mode = !free_q && (policy_q == POL_BEST);
	assign match     = free_q ? (used_q[idx_q] && (owner_q[idx_q] == own_q))
	                          : (!used_q[idx_q] && (size_q[idx_q] >= req_q));
	assign idx_wrap  = (CW'(idx_q) + CW'(1)) >= count_q;
	assign exact     = size_q[p] == req_q;
	assign lo_merge  = (p != '0) && !used_q[p - IW'(1)];
	assign hi_merge  = ((CW'(p) + CW'(1)) < count_q) && !used_q[p + IW'(1)];
	assign hi_count  = hi_merge ? (count_q - CW'(1)) : count_q;

	always_comb begin
		lo_rover = rover_q;
		if (lo_merge && (rover_q >= p) && (rover_q != '0)) begin
			lo_rover = rover_q - IW'(1);
		end
		hi_rover1 = rover_q;
		if (hi_merge && (int'(rover_q) >= int'(p) + 1) && (rover_q != '0)) begin
			hi_rover1 = rover_q - IW'(1);
		end
		hi_rover = (CW'(hi_rover1) >= hi_count) ? '0 : hi_rover1;
	end

	always_comb begin
		stat.is_free  = free_q;
		stat.scan_end = (step_q >= count_q) || (found_q && !best_mode);
		stat.found    = found_q;
		stat.req_zero = req_q == '0;
		stat.exact    = exact;
		stat.full     = count_q >= CW'(MAX_ENTRIES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				start_q[j] <= '0;
				size_q[j]  <= '0;
				used_q[j]  <= 1'b0;
				owner_q[j] <= '0;
			end
			start_q[0]   <= RESET_BASE;
			size_q[0]    <= RESET_SIZE;
			count_q      <= CW'(1);
			rover_q      <= '0;
			policy_q     <= POL_FIRST;
			base_q       <= RESET_BASE;
			psize_q      <= RESET_SIZE;
			step_q       <= '0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			res_status_q <= ST_OK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY: policy_q <= cfg_data[1:0];
				CFG_BASE: begin
					base_q     <= cfg_data;
					start_q[0] <= cfg_data;
					size_q[0]  <= psize_q;
					used_q[0]  <= 1'b0;
					owner_q[0] <= '0;
					count_q    <= CW'(1);
					rover_q    <= '0;
				end
				CFG_SIZE: begin
					psize_q    <= cfg_data;
					start_q[0] <= base_q;
					size_q[0]  <= cfg_data;
					used_q[0]  <= 1'b0;
					owner_q[0] <= '0;
					count_q    <= CW'(1);
					rover_q    <= '0;
				end
				default: ;
			endcase
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					free_q  <= in_cmd;
					own_q   <= in_owner;
					req_q   <= in_size;
					found_q <= 1'b0;
					step_q  <= '0;
					// Next fit starts at the rover; everything else at the bottom.
					idx_q   <= ((in_cmd == CMD_ALLOC) && (policy_q == POL_NEXT) &&
					            (CW'(rover_q) < count_q)) ? rover_q : '0;
				end
				OP_STEP: begin
					if (match && (!found_q || (best_mode && (size_q[idx_q] < best_q)))) begin
						pick_q  <= idx_q;
						best_q  <= size_q[idx_q];
						found_q <= 1'b1;
					end
					idx_q  <= idx_wrap ? '0 : idx_q + IW'(1);
					step_q <= step_q + CW'(1);
				end
				OP_ALLOC: begin
					if (!exact) begin
						for (int j = 1; j < MAX_ENTRIES; j++) begin
							if ((j > int'(p) + 1) && (j <= int'(count_q))) begin
								start_q[j] <= start_q[j-1];
								size_q[j]  <= size_q[j-1];
								used_q[j]  <= used_q[j-1];
								owner_q[j] <= owner_q[j-1];
							end
							if (j == int'(p) + 1) begin
								start_q[j] <= start_q[p] + req_q;
								size_q[j]  <= size_q[p] - req_q;
								used_q[j]  <= 1'b0;
								owner_q[j] <= '0;
							end
						end
						size_q[p] <= req_q;
						count_q   <= count_q + CW'(1);
					end
					used_q[p]  <= 1'b1;
					owner_q[p] <= own_q;
					rover_q    <= p;
					rel_q      <= start_q[p];
				end
				OP_MERGE_LO: begin
					rel_q      <= start_q[p];
					used_q[p]  <= 1'b0;
					owner_q[p] <= '0;
					if (lo_merge) begin
						size_q[p - IW'(1)] <= size_q[p - IW'(1)] + size_q[p];
						for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
							if (j >= int'(p)) begin
								start_q[j] <= start_q[j+1];
								size_q[j]  <= size_q[j+1];
								used_q[j]  <= used_q[j+1];
								owner_q[j] <= owner_q[j+1];
							end
						end
						count_q <= count_q - CW'(1);
						pick_q  <= p - IW'(1);
					end
					rover_q <= lo_rover;
				end
				OP_MERGE_HI: begin
					if (hi_merge) begin
						size_q[p] <= size_q[p] + size_q[p + IW'(1)];
						for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
							if (j >= int'(p) + 1) begin
								start_q[j] <= start_q[j+1];
								size_q[j]  <= size_q[j+1];
								used_q[j]  <= used_q[j+1];
								owner_q[j] <= owner_q[j+1];
							end
						end
					end
					count_q <= hi_count;
					rover_q <= hi_rover;
				end
				OP_RESULT: begin
					res_status_q <= cmd.code;
					res_start_q  <= (cmd.code == ST_OK) ? rel_q : '0;
				end
				default: ;
			endcase
		end
	end

	assign res_status = res_status_q;
	assign res_start  = res_start_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CW'(MAX_ENTRIES)))
		else $error("partition count out of range");

	a_rover_inside: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(rover_q) < count_q)
		else $error("rover points beyond the table");

	a_alloc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ALLOC) && !cfg_we |=> used_q[$past(pick_q)])
		else $error("allocated partition not marked used");

endmodule
`default_nettype wire

// ----- design/vpa_ctrl.sv -----
`default_nettype none
module vpa_ctrl (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire  logic              out_ready,
	input  wire  logic              cfg_valid,
	output logic                    cfg_ready,
	input  wire  vpa_pkg::dp_stat_t stat,
	output vpa_pkg::dp_cmd_t        cmd
);
	import vpa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.code  = ST_OK;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// A pending register write goes first; the request waits until no write is pending.
				cfg_ready = 1'b1;
				in_ready  = !cfg_valid;
				if (in_valid && !cfg_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (stat.scan_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.op = OP_STEP;
				end
			end
			S_DECIDE: begin
				if (stat.is_free) begin
					if (stat.found) begin
						cmd.op  = OP_MERGE_LO;
						state_d = S_MERGE;
					end else begin
						cmd.op   = OP_RESULT;
						cmd.code = ST_NOOWNER;
						state_d  = S_OUT;
					end
				end else if (stat.req_zero || !stat.found) begin
					cmd.op   = OP_RESULT;
					cmd.code = ST_NOSPACE;
					state_d  = S_OUT;
				end else if (!stat.exact && stat.full) begin
					cmd.op   = OP_RESULT;
					cmd.code = ST_FULL;
					state_d  = S_OUT;
				end else begin
					cmd.op  = OP_ALLOC;
					state_d = S_FINISH;
				end
			end
			S_MERGE: begin
				cmd.op  = OP_MERGE_HI;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.op   = OP_RESULT;
				cmd.code = ST_OK;
				state_d  = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/variable_partition_allocator.sv -----
// Channel   Direction  Signals                              Contents
// s_axis    in         tvalid tready tdata[23:0] tuser[0]   one request
// m_axis    out        tvalid tready tdata[15:0] tuser[1:0] one answer
// cfg       in         valid ready index[1:0] data[15:0]    register write
//
// A request walks the partition table, one entry a cycle, before its answer is valid.
// Splits and merges shift the table entries above the affected partition.
// Reset builds a table of one free partition of 600 units at address 40.
// A new request is taken only after the answer transaction has completed.
// Register writes are taken only while no request is in flight and win over a request.
`default_nettype none
module variable_partition_allocator #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  logic [23:0] s_axis_tdata,  // owner_id[7:0], request_size[23:8]
	input  wire  logic        s_axis_tuser,  // cmd
	output logic              m_axis_tvalid,
	input  wire  logic        m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // block_start[15:0]
	output logic [1:0]        m_axis_tuser,  // status_code[1:0]
	input  wire  logic        cfg_valid,
	output logic              cfg_ready,
	input  wire  logic [1:0]  cfg_index,
	input  wire  logic [15:0] cfg_data
);
	import vpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	vpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vpa_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_cmd     (s_axis_tuser),
		.in_owner   (s_axis_tdata[7:0]),
		.in_size    (s_axis_tdata[23:8]),
		.cmd        (cmd),
		.stat       (stat),
		.res_status (m_axis_tuser),
		.res_start  (m_axis_tdata)
	);

endmodule
`default_nettype wire
